[rtl/ulwc_pkg.sv]
// ----------------------------------------------------------------------------
// ulwc_pkg
// Shared types and constants for the UTF-8 Latin word counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ulwc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] FOLD_LIMIT  = 8'hE0;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] LOWER_START = 8'h61;
  localparam logic [7:0] CHAR_APOS   = 8'h27;
  localparam logic [7:0] CHAR_CCED   = 8'hC7;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_E      = 8'h45;
  localparam logic [7:0] CHAR_I      = 8'h49;
  localparam logic [7:0] CHAR_O      = 8'h4F;
  localparam logic [7:0] CHAR_U      = 8'h55;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_LA     = 8'h61;
  localparam logic [7:0] CHAR_LZ     = 8'h7A;
  localparam logic [5:0] CONT_MASK   = 6'h3F;

  // one decoded event handed from the decoder to the word logic
  typedef struct packed {
    logic is_eof;
    logic letter;
    logic vowel;
  } ulwc_event_t;

  typedef struct packed {
    logic letter;
    logic vowel;
  } ulwc_class_t;

  function automatic logic accented_vowel(logic [7:0] f);
    accented_vowel = (f >= 8'hC0 && f <= 8'hC3) || (f >= 8'hC8 && f <= 8'hCA) ||
                     (f >= 8'hCC && f <= 8'hCD) || (f >= 8'hD2 && f <= 8'hD5) ||
                     (f >= 8'hD9 && f <= 8'hDA);
  endfunction

  // anything at or above 0x100 folds out of every letter range
  function automatic ulwc_class_t classify(logic [31:0] cp);
    logic        low_only;
    logic [7:0]  c;
    logic [7:0]  f;
    logic [7:0]  g;
    logic        lv;
    ulwc_class_t r;
    low_only = (cp[31:8] == 24'd0);
    c        = cp[7:0];
    f        = (c >= FOLD_LIMIT) ? c - CASE_OFFSET : c;
    g        = (f >= LOWER_START) ? f - CASE_OFFSET : f;
    lv       = accented_vowel(f);
    r.letter = low_only && ((f >= CHAR_A && f <= CHAR_Z) || (f >= CHAR_LA && f <= CHAR_LZ) ||
                            f == CHAR_APOS || f == CHAR_CCED || lv);
    r.vowel  = low_only && (g == CHAR_A || g == CHAR_E || g == CHAR_I || g == CHAR_O ||
                            g == CHAR_U || lv);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/utf8_latin_word_counter.sv]
// ----------------------------------------------------------------------------
// utf8_latin_word_counter
// Counts Portuguese words in a UTF-8 byte stream and reports running totals.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the queue has room. A decoder rebuilds
// and classifies code points and hands them through a four-entry queue to
// the word logic; an end-of-file request yields one result of three saturating
// totals, held in an output register that frees the decoder to keep accepting
// bytes while the result waits. The queue fills only while a result is stalled
// and another end-of-file arrives. An end-of-file request passes a queue slot
// and then the output register before its result appears.
`default_nettype none

module utf8_latin_word_counter import ulwc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_file,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] word_total,
  output      logic [31:0] vowel_start_total,
  output      logic [31:0] consonant_end_total
);

  logic        accept;
  logic        push;
  ulwc_event_t push_event;
  logic        full;
  logic        head_valid;
  ulwc_event_t head_event;
  logic        pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ulwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text_byte),
    .end_of_file(end_of_file),
    .push       (push),
    .push_event (push_event)
  );

  ulwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_event(push_event),
    .full      (full),
    .head_valid(head_valid),
    .head_event(head_event),
    .pop       (pop)
  );

  ulwc_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .head_valid         (head_valid),
    .head_event         (head_event),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .word_total         (word_total),
    .vowel_start_total  (vowel_start_total),
    .consonant_end_total(consonant_end_total)
  );

endmodule

`default_nettype wire

[rtl/ulwc_front.sv]
// ----------------------------------------------------------------------------
// ulwc_front
// Byte decoder: rebuilds code points from UTF-8 bytes and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module ulwc_front import ulwc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_file,
  output      logic        push,
  output      ulwc_event_t push_event
);

  logic [2:0]  pending, pending_next;
  logic [31:0] acc, acc_next;
  logic [31:0] cont_bits;
  logic [31:0] contrib;
  logic [31:0] code;
  logic        has_code;
  ulwc_class_t cls;

  assign cont_bits = {26'd0, text_byte[5:0] & CONT_MASK};

  // weight of a continuation byte by how many are still owed
  always_comb begin
    unique case (pending)
      3'd1:    contrib = cont_bits;
      3'd2:    contrib = cont_bits << 6;
      3'd3:    contrib = cont_bits << 12;
      3'd4:    contrib = cont_bits << 18;
      3'd5:    contrib = cont_bits << 24;
      3'd6:    contrib = cont_bits << 30;
      default: contrib = 32'd0;
    endcase
  end

  always_comb begin
    pending_next = pending;
    acc_next     = acc;
    has_code     = 1'b0;
    code         = acc + contrib;
    if (end_of_file) begin
      pending_next = 3'd0;
      acc_next     = 32'd0;
    end else if (pending != 3'd0) begin
      pending_next = pending - 3'd1;
      acc_next     = acc + contrib;
      if (pending == 3'd1) begin
        has_code = 1'b1;
        acc_next = 32'd0;
      end
    end else begin
      unique casez (text_byte)
        8'b0???????: begin
          has_code = 1'b1;
          code     = {24'd0, text_byte};
        end
        8'b10??????: begin
          // stray continuation byte decodes on its own
          has_code = 1'b1;
          code     = {26'd0, text_byte[5:0]};
        end
        8'b110?????: begin
          pending_next = 3'd1;
          acc_next     = {21'd0, text_byte[4:0], 6'd0};
        end
        8'b1110????: begin
          pending_next = 3'd2;
          acc_next     = {16'd0, text_byte[3:0], 12'd0};
        end
        8'b11110???: begin
          pending_next = 3'd3;
          acc_next     = {11'd0, text_byte[2:0], 18'd0};
        end
        8'b111110??: begin
          pending_next = 3'd4;
          acc_next     = {6'd0, text_byte[1:0], 24'd0};
        end
        8'b1111110?: begin
          pending_next = 3'd5;
          acc_next     = {1'b0, text_byte[0], 30'd0};
        end
        8'b11111110: begin
          pending_next = 3'd6;
          acc_next     = 32'd0;
        end
        default: begin
          pending_next = 3'd7;
          acc_next     = 32'd0;
        end
      endcase
    end
  end

  assign cls               = classify(code);
  assign push              = accept && (end_of_file || has_code);
  assign push_event.is_eof = end_of_file;
  assign push_event.letter = cls.letter;
  assign push_event.vowel  = cls.vowel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
      acc     <= 32'd0;
    end else if (accept) begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ulwc_queue.sv]
// ----------------------------------------------------------------------------
// ulwc_queue
// Short event queue between the decoder and the word logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ulwc_queue import ulwc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire ulwc_event_t push_event,
  output      logic        full,
  output      logic        head_valid,
  output      ulwc_event_t head_event,
  input  wire logic        pop
);

  ulwc_event_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [QPTR_W:0]       count;
  logic                  do_push, do_pop;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_event = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ulwc_back.sv]
// ----------------------------------------------------------------------------
// ulwc_back
// Word tracking, saturating totals and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ulwc_back import ulwc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire ulwc_event_t head_event,
  output      logic        pop,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] word_total,
  output      logic [31:0] vowel_start_total,
  output      logic [31:0] consonant_end_total
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  inside_word, inside_word_next;
  logic                  last_vowel, last_vowel_next;
  logic [COUNT_BITS-1:0] words, words_next;
  logic [COUNT_BITS-1:0] vstarts, vstarts_next;
  logic [COUNT_BITS-1:0] cends, cends_next;
  logic                  out_load;

  function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] clip32(logic [COUNT_BITS-1:0] v);
    logic [64:0] w;
    w = {{(65-COUNT_BITS){1'b0}}, v};
    return (w > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  // a result event waits until the result register is free
  assign pop      = head_valid && (!head_event.is_eof || !out_valid || !out_stall);
  assign out_load = pop && head_event.is_eof;

  always_comb begin
    inside_word_next = inside_word;
    last_vowel_next  = last_vowel;
    words_next       = words;
    vstarts_next     = vstarts;
    cends_next       = cends;
    if (!inside_word) begin
      if (!head_event.is_eof && head_event.letter) begin
        inside_word_next = 1'b1;
        last_vowel_next  = head_event.vowel;
        if (head_event.vowel) vstarts_next = bump(vstarts);
      end
    end else if (!head_event.is_eof && head_event.letter) begin
      last_vowel_next = head_event.vowel;
    end else begin
      inside_word_next = 1'b0;
      words_next       = bump(words);
      if (!last_vowel) cends_next = bump(cends);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word <= 1'b0;
      last_vowel  <= 1'b0;
      words       <= '0;
      vstarts     <= '0;
      cends       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        inside_word <= inside_word_next;
        last_vowel  <= last_vowel_next;
        words       <= words_next;
        vstarts     <= vstarts_next;
        cends       <= cends_next;
      end
      if (out_load)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      word_total          <= clip32(words_next);
      vowel_start_total   <= clip32(vstarts_next);
      consonant_end_total <= clip32(cends_next);
    end
  end

endmodule

`default_nettype wire

[rtl/ulwc_checker.sv]
// ----------------------------------------------------------------------------
// ulwc_checker
// Port-level checks for the word counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ulwc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] word_total,
  input wire logic [31:0] vowel_start_total,
  input wire logic [31:0] consonant_end_total
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // a consonant ending is only counted as a word closes
  a_cends_le_words: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> consonant_end_total <= word_total)
    else $error("consonant endings exceed words");

  // at most one open word has a counted start but no word count yet
  a_vstarts_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, vowel_start_total} <= {1'b0, word_total} + 33'd1)
    else $error("vowel starts exceed words plus one");

endmodule

bind utf8_latin_word_counter ulwc_checker u_ulwc_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .word_total         (word_total),
  .vowel_start_total  (vowel_start_total),
  .consonant_end_total(consonant_end_total)
);

`default_nettype wire

[bench/ulwc_tally_pkg.sv]
// ----------------------------------------------------------------------------
// ulwc_tally_pkg
// Scoreboard for the UTF-8 Latin word counter bench: decodes each accepted
// request the way the block should, keeps the expected totals in order and
// compares them with the totals the block hands out.
// ----------------------------------------------------------------------------
package ulwc_tally_pkg;

  typedef struct packed {
    logic [31:0] words;
    logic [31:0] vowel_starts;
    logic [31:0] consonant_ends;
  } totals_t;

  class word_tally_board #(int CW = 32);
    logic [2:0]  owed_bytes;
    logic [31:0] code_sum;
    bit          in_word;
    bit          last_vowel;
    logic [63:0] n_words;
    logic [63:0] n_vowel_lead;
    logic [63:0] n_cons_tail;
    totals_t     expected_totals[$];
    int          fail_count;

    function new();
      owed_bytes   = '0;
      code_sum     = '0;
      in_word      = 1'b0;
      last_vowel   = 1'b0;
      n_words      = '0;
      n_vowel_lead = '0;
      n_cons_tail  = '0;
      fail_count   = 0;
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction

    // counters stick at their all-ones value
    function logic [63:0] bumped(logic [63:0] v);
      logic [63:0] top;
      top = (64'd1 << CW) - 64'd1;
      return (v < top) ? v + 64'd1 : v;
    endfunction

    function logic [31:0] clip32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function bit accented(logic [31:0] f);
      return (f >= 32'hC0 && f <= 32'hC3) || (f >= 32'hC8 && f <= 32'hCA) ||
             (f >= 32'hCC && f <= 32'hCD) || (f >= 32'hD2 && f <= 32'hD5) ||
             (f >= 32'hD9 && f <= 32'hDA);
    endfunction

    // payload bits pushed past bit 31 are lost
    function logic [31:0] placed(logic [7:0] bits, int sh);
      return (sh < 32) ? ({24'd0, bits} << sh) : 32'd0;
    endfunction

    function void end_word();
      if (in_word) begin
        if (!last_vowel) n_cons_tail = bumped(n_cons_tail);
        n_words = bumped(n_words);
        in_word = 1'b0;
      end
    endfunction

    function void take_code(logic [31:0] cp);
      logic [31:0] f;
      logic [31:0] g;
      bit          letter;
      bit          vowel;
      f = (cp >= 32'hE0) ? cp - 32'h20 : cp;
      g = (f >= 32'h61) ? f - 32'h20 : f;
      letter = (f >= 32'h41 && f <= 32'h5A) || (f >= 32'h61 && f <= 32'h7A) ||
               f == 32'h27 || f == 32'hC7 || accented(f);
      vowel  = g == 32'h41 || g == 32'h45 || g == 32'h49 || g == 32'h4F ||
               g == 32'h55 || accented(f);
      if (!in_word) begin
        if (letter) begin
          in_word = 1'b1;
          if (vowel) n_vowel_lead = bumped(n_vowel_lead);
          last_vowel = vowel;
        end
      end else if (letter) begin
        last_vowel = vowel;
      end else begin
        end_word();
      end
    endfunction

    function void note_request(logic [7:0] b, logic eof);
      int          n;
      logic [7:0]  mask;
      totals_t     t;
      if (eof) begin
        owed_bytes = '0;
        code_sum   = '0;
        end_word();
        t.words          = clip32(n_words);
        t.vowel_starts   = clip32(n_vowel_lead);
        t.consonant_ends = clip32(n_cons_tail);
        expected_totals.push_back(t);
      end else if (owed_bytes != 0) begin
        // any byte counts as a continuation here
        code_sum   = code_sum + placed(b & 8'h3F, 6 * (int'(owed_bytes) - 1));
        owed_bytes = owed_bytes - 3'd1;
        if (owed_bytes == 0) begin
          take_code(code_sum);
          code_sum = '0;
        end
      end else if (!b[7]) begin
        take_code({24'd0, b});
      end else begin
        n = 1;
        while (n < 8 && b[7 - n]) n++;
        mask = (n < 8) ? (8'd1 << (7 - n)) - 8'd1 : 8'd0;
        if (n == 1) begin
          take_code({24'd0, b & mask});
        end else begin
          code_sum   = placed(b & mask, 6 * (n - 1));
          owed_bytes = 3'(n - 1);
        end
      end
    endfunction

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (fail_count <= 40)
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    endtask

    task check_totals(logic [31:0] w, logic [31:0] v, logic [31:0] c);
      totals_t t;
      if (expected_totals.size() == 0) begin
        report_mismatch("result with no request behind it", 32'd0, w);
      end else begin
        t = expected_totals.pop_front();
        if (w !== t.words) report_mismatch("word_total", t.words, w);
        if (v !== t.vowel_starts) report_mismatch("vowel_start_total", t.vowel_starts, v);
        if (c !== t.consonant_ends)
          report_mismatch("consonant_end_total", t.consonant_ends, c);
      end
    endtask
  endclass

endpackage

[bench/utf8_latin_word_counter_test.sv]
// ----------------------------------------------------------------------------
// utf8_latin_word_counter_test
// Drives text bytes and end-of-file requests into the word counter with
// random gaps and output stalls, predicts the totals of every end-of-file
// request and checks each result against them in order.
// ----------------------------------------------------------------------------
module utf8_latin_word_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ulwc_tally_pkg::*;

  // narrow counters so saturation is reached within the run
  localparam int COUNT_W     = 8;
  localparam int ITEMS       = 1800;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [7:0] ACCENTED [15] = '{
    8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC8, 8'hC9, 8'hCA, 8'hCC,
    8'hCD, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD9, 8'hDA
  };

  // {end_of_file, text_byte}
  localparam logic [8:0] OPENING [24] = '{
    9'h041, 9'h062, 9'h020,                      // vowel start, consonant end
    9'h027, 9'h0C3, 9'h087, 9'h0C3, 9'h0A9,      // apostrophe, c-cedilla, e-acute
    9'h000,                                      // zero byte ends the word
    9'h0A7, 9'h080,                              // stray continuations as leads
    9'h0FF, 9'h0BF, 9'h084, 9'h080, 9'h080,      // 0xff lead, shifted-out payload
    9'h080, 9'h081, 9'h081,
    9'h100,
    9'h075, 9'h0E2, 9'h082, 9'h100               // file ends mid-character
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'd0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] word_total;
  logic [31:0] vowel_start_total;
  logic [31:0] consonant_end_total;

  word_tally_board #(COUNT_W) board;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_request   = 0;
  int requests_sent  = 0;
  int cycle_count    = 0;

  utf8_latin_word_counter #(.COUNT_BITS(COUNT_W)) i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .text_byte           (text_byte),
    .end_of_file         (end_of_file),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .word_total          (word_total),
    .vowel_start_total   (vowel_start_total),
    .consonant_end_total (consonant_end_total)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_latin_word_counter verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_totals(word_total, vowel_start_total, consonant_end_total);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_request(input logic [7:0] b, input logic eof);
    int gap;
    gap = sender_idles ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    board.note_request(b, eof);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_eof();
    push_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_char(input logic [31:0] cp);
    if (cp < 32'h80) begin
      push_request(cp[7:0], 1'b0);
    end else if (cp < 32'h800) begin
      push_request({3'b110, cp[10:6]}, 1'b0);
      push_request({2'b10, cp[5:0]}, 1'b0);
    end else if (cp < 32'h10000) begin
      push_request({4'b1110, cp[15:12]}, 1'b0);
      push_request({2'b10, cp[11:6]}, 1'b0);
      push_request({2'b10, cp[5:0]}, 1'b0);
    end else begin
      push_request({5'b11110, cp[20:18]}, 1'b0);
      push_request({2'b10, cp[17:12]}, 1'b0);
      push_request({2'b10, cp[11:6]}, 1'b0);
      push_request({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  function automatic logic [31:0] pick_letter();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'h61 + $urandom_range(0, 25);
      4, 5:       return 32'h41 + $urandom_range(0, 25);
      6: begin
        case ($urandom_range(0, 2))
          0:       return 32'h27;
          1:       return 32'hC7;
          default: return 32'hE7;
        endcase
      end
      default: return {24'd0, ACCENTED[$urandom_range(0, 14)] |
                              ($urandom_range(0, 1) ? 8'h20 : 8'h00)};
    endcase
  endfunction

  function automatic logic [31:0] pick_separator();
    case ($urandom_range(0, 7))
      0, 1, 2: return 32'h20;
      3:       return 32'h21 + $urandom_range(0, 30);
      4:       return 32'h0A;
      5:       return 32'hA0 + $urandom_range(0, 95);
      6:       return 32'h2000 + $urandom_range(0, 32'hFFF);
      default: return 32'h1F600 + $urandom_range(0, 79);
    endcase
  endfunction

  // output side: stalls each result at random, or holds one result long on request
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (hold_request != 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = receiver_idles ? $urandom_range(0, 7) : 0;
      end
      out_stall <= (gap != 0);
      do @(posedge clk); while (!out_valid);
      if (gap != 0) begin
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
      @(negedge clk);
    end
  end

  initial begin
    int sel;
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) push_request(OPENING[i][7:0], OPENING[i][8]);

    // sender waits until every result is back
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);

    // long output hold while end-of-file requests pile up behind it
    sender_idles = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (10) begin
      send_char(pick_letter());
      send_eof();
    end
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    sender_idles = 1'b1;

    while (requests_sent < ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        sender_idles   = ($urandom_range(0, 2) != 0);
        receiver_idles = ($urandom_range(0, 2) != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        repeat ($urandom_range(1, 7)) send_char(pick_letter());
        send_char(pick_separator());
      end else if (sel < 80) begin
        send_char(pick_separator());
      end else if (sel < 88) begin
        repeat ($urandom_range(1, 6)) push_request(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 94) begin
        // truncated sequence: whatever follows is taken as continuation
        push_request(8'hC0 | 8'($urandom_range(0, 63)), 1'b0);
        repeat ($urandom_range(0, 3))
          push_request(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
      end else begin
        // overlong two-byte form of an ascii code
        push_request(8'hC1, 1'b0);
        push_request(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
      end
      if ($urandom_range(0, 7) == 0) send_eof();
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (board.fail_count == 0) begin
      $display("utf8_latin_word_counter verification clean");
    end else begin
      $display("utf8_latin_word_counter verification failed");
    end
    $finish;
  end

endmodule
